// File: rtl/cpp_pkg.sv
// shared constants for the compound poisson probability block
package cpp_pkg;
  localparam int MAX_ORDER    = 15;
  localparam int ADDR_W       = $clog2(MAX_ORDER + 1);
  localparam int ORD_W        = 4;
  localparam int DVD_W        = 64;
  localparam int DVS_W        = 36;
  localparam int EXP_TERMS    = 12;
  localparam logic [ORD_W-1:0] ORDER_RESET = 4'd8;
  localparam logic [15:0]      P_CLAMP     = 16'd65470;
  localparam logic [31:0]      Q31_ONE     = 32'h8000_0000;
  localparam logic [39:0]      SUM_SAT     = 40'hFF_FFFF_FFFF >> 1;
endpackage

// File: rtl/cpp_ram.sv
// generic single write port ram with registered read
module cpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/cpp_div.sv
// iterative restoring divider, one quotient bit per cycle
module cpp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cpp_pkg::DVD_W-1:0] dividend,
  input  logic [cpp_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [cpp_pkg::DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(cpp_pkg::DVD_W + 1);

  logic                      run_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [cpp_pkg::DVS_W:0]   rem_r;
  logic [cpp_pkg::DVD_W-1:0] quo_r;
  logic [cpp_pkg::DVS_W-1:0] dvs_r;
  logic [cpp_pkg::DVS_W:0]   trial;
  logic                      fits;

  // trial subtract
  assign trial = {rem_r[cpp_pkg::DVS_W-1:0], quo_r[cpp_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_W'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(cpp_pkg::DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= fits ? (trial - {1'b0, dvs_r}) : trial;
      quo_r <= {quo_r[cpp_pkg::DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// File: rtl/compound_poisson_probabilities.sv
// top level: panjer recursion sequencer with shared multiplier and divider
// ord is max_order held to 1..15; every divide holds the shared divider until it is done
// one request at a time, in_ready only in idle
// reset: synchronous active low, returns to idle and max_order goes to 8
module compound_poisson_probabilities (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_mean_primaries,
  input  logic [15:0] in_crosstalk_prob,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_count_index,
  output logic [31:0] out_probability,
  output logic        out_last_term,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);
  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001, S_EXP_M = 22'h000002, S_EXP_D = 22'h000004,
    S_DIVW  = 22'h000008, S_EXP_R = 22'h000010, S_G_M   = 22'h000020,
    S_G_D   = 22'h000040, S_G_R   = 22'h000080, S_SQ_M  = 22'h000100,
    S_SQ_R  = 22'h000200, S_RD    = 22'h000400, S_RC_M  = 22'h000800,
    S_RC_K  = 22'h001000, S_RC_A  = 22'h002000, S_FN_M  = 22'h004000,
    S_FN_H  = 22'h008000, S_FN_D  = 22'h010000, S_FN_R  = 22'h020000,
    S_NR_RD = 22'h040000, S_NR_D  = 22'h080000, S_NR_R  = 22'h100000,
    S_OUT   = 22'h200000
  } state_t;

  localparam int AW = cpp_pkg::ADDR_W;

  state_t                    state_r, div_ret_r;
  logic [cpp_pkg::ORD_W-1:0] max_order_r, ord_r;
  logic [3:0]                k_r, n_r;
  logic [2:0]                i_r;
  logic                      exp_sel_r;
  logic [23:0]               mu_r;
  logic [31:0]               p31_r, y_r, r_r, gp_r, out_prob_r;
  logic [39:0]               s_r;
  logic [35:0]               tot_r;
  logic [63:0]               prod_r, lo_r;
  logic [31:0]               mul_a, mul_b;
  logic [cpp_pkg::ORD_W-1:0] ord_eff;
  logic [15:0]               pq_clamp;

  logic                      div_start, div_done;
  logic [cpp_pkg::DVD_W-1:0] div_dvd, div_quo;
  logic [cpp_pkg::DVS_W-1:0] div_dvs;
  logic [63:0]               fn_full;
  logic [31:0]               exp_new, fn_val;
  logic [40:0]               s_sum;

  logic          g_we, p_we;
  logic [AW-1:0] g_waddr, p_waddr, g_raddr, p_raddr;
  logic [31:0]   g_wdata, p_wdata, g_rdata, p_rdata;

  // request decode
  assign pq_clamp = (in_crosstalk_prob > cpp_pkg::P_CLAMP) ? cpp_pkg::P_CLAMP
                                                           : in_crosstalk_prob;
  assign ord_eff  = (max_order_r == '0) ? cpp_pkg::ORD_W'(1) :
                    (32'(max_order_r) > cpp_pkg::MAX_ORDER) ?
                    cpp_pkg::ORD_W'(cpp_pkg::MAX_ORDER) : max_order_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_EXP_M: begin mul_a = y_r;  mul_b = r_r; end
      S_G_M:   begin mul_a = gp_r; mul_b = p31_r; end
      S_SQ_M:  begin mul_a = r_r;  mul_b = r_r; end
      S_RC_M:  begin mul_a = g_rdata; mul_b = p_rdata; end
      S_RC_K:  begin mul_a = prod_r[62:31]; mul_b = {28'd0, k_r}; end
      S_FN_M:  begin mul_a = s_r[31:0]; mul_b = {8'd0, mu_r}; end
      S_FN_H:  begin mul_a = {24'd0, s_r[39:32]}; mul_b = {8'd0, mu_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // shared divider operand select
  assign fn_full = lo_r + {prod_r[31:0], 32'd0};
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_r)
      S_EXP_D: begin
        div_start = 1'b1;
        div_dvd   = {31'd0, prod_r[63:31]};
        div_dvs   = {32'd0, k_r};
      end
      S_G_D: begin
        div_start = 1'b1;
        div_dvd   = {31'd0, prod_r[63:31]};
        div_dvs   = {32'd0, k_r - 4'd1};
      end
      S_FN_D: begin
        div_start = 1'b1;
        div_dvd   = {18'd0, fn_full[63:18]};
        div_dvs   = {32'd0, n_r};
      end
      S_NR_D: begin
        div_start = (tot_r != '0);
        div_dvd   = {1'b0, p_rdata, 31'd0};
        div_dvs   = tot_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // result shaping
  assign exp_new = cpp_pkg::Q31_ONE - div_quo[31:0];
  assign fn_val  = (div_quo > {32'd0, cpp_pkg::Q31_ONE}) ? cpp_pkg::Q31_ONE : div_quo[31:0];
  assign s_sum   = {1'b0, s_r} + {6'd0, prod_r[34:0]};

  // memory ports
  assign g_we    = (state_r == S_EXP_R && k_r == 4'd1 && !exp_sel_r) || (state_r == S_G_R);
  assign g_waddr = (state_r == S_G_R) ? AW'(k_r) : AW'(1);
  assign g_wdata = (state_r == S_G_R) ? div_quo[31:0] : exp_new;
  assign g_raddr = AW'(k_r);
  assign p_we    = (state_r == S_SQ_R && i_r == 3'd5) || (state_r == S_FN_R);
  assign p_waddr = (state_r == S_FN_R) ? AW'(n_r) : AW'(0);
  assign p_wdata = (state_r == S_FN_R) ? fn_val : prod_r[62:31];
  assign p_raddr = (state_r == S_NR_RD) ? AW'(n_r) : AW'(n_r - k_r);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_order_r <= cpp_pkg::ORDER_RESET;
    end else begin
      if (cfg_we) begin
        max_order_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mu_r      <= in_mean_primaries;
            p31_r     <= {1'b0, pq_clamp, 15'd0};
            y_r       <= {1'b0, pq_clamp, 15'd0};
            ord_r     <= ord_eff;
            r_r       <= cpp_pkg::Q31_ONE;
            k_r       <= 4'(cpp_pkg::EXP_TERMS);
            exp_sel_r <= 1'b0;
            state_r   <= S_EXP_M;
          end
        end
        S_EXP_M: state_r <= S_EXP_D;
        S_EXP_D: begin
          div_ret_r <= S_EXP_R;
          state_r   <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            state_r <= div_ret_r;
          end
        end
        S_EXP_R: begin
          if (k_r != 4'd1) begin
            r_r     <= exp_new;
            k_r     <= k_r - 4'd1;
            state_r <= S_EXP_M;
          end else if (exp_sel_r) begin
            r_r     <= exp_new;
            i_r     <= '0;
            state_r <= S_SQ_M;
          end else begin
            gp_r <= exp_new;
            if (ord_r == 4'd1) begin
              exp_sel_r <= 1'b1;
              y_r       <= {1'b0, mu_r, 7'd0};
              r_r       <= cpp_pkg::Q31_ONE;
              k_r       <= 4'(cpp_pkg::EXP_TERMS);
              state_r   <= S_EXP_M;
            end else begin
              k_r     <= 4'd2;
              state_r <= S_G_M;
            end
          end
        end
        S_G_M: state_r <= S_G_D;
        S_G_D: begin
          div_ret_r <= S_G_R;
          state_r   <= S_DIVW;
        end
        S_G_R: begin
          gp_r <= div_quo[31:0];
          if (k_r == ord_r) begin
            exp_sel_r <= 1'b1;
            y_r       <= {1'b0, mu_r, 7'd0};
            r_r       <= cpp_pkg::Q31_ONE;
            k_r       <= 4'(cpp_pkg::EXP_TERMS);
            state_r   <= S_EXP_M;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_G_M;
          end
        end
        S_SQ_M: state_r <= S_SQ_R;
        S_SQ_R: begin
          r_r <= prod_r[62:31];
          if (i_r == 3'd5) begin
            tot_r   <= {4'd0, prod_r[62:31]};
            n_r     <= 4'd1;
            k_r     <= 4'd1;
            s_r     <= '0;
            state_r <= S_RD;
          end else begin
            i_r     <= i_r + 3'd1;
            state_r <= S_SQ_M;
          end
        end
        S_RD:   state_r <= S_RC_M;
        S_RC_M: state_r <= S_RC_K;
        S_RC_K: state_r <= S_RC_A;
        S_RC_A: begin
          s_r <= (s_sum > {1'b0, cpp_pkg::SUM_SAT}) ? cpp_pkg::SUM_SAT : s_sum[39:0];
          if (k_r == n_r) begin
            state_r <= S_FN_M;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_RD;
          end
        end
        S_FN_M: state_r <= S_FN_H;
        S_FN_H: begin
          lo_r    <= prod_r;
          state_r <= S_FN_D;
        end
        S_FN_D: begin
          div_ret_r <= S_FN_R;
          state_r   <= S_DIVW;
        end
        S_FN_R: begin
          tot_r <= tot_r + {4'd0, fn_val};
          if (n_r == ord_r) begin
            n_r     <= '0;
            state_r <= S_NR_RD;
          end else begin
            n_r     <= n_r + 4'd1;
            k_r     <= 4'd1;
            s_r     <= '0;
            state_r <= S_RD;
          end
        end
        S_NR_RD: state_r <= S_NR_D;
        S_NR_D: begin
          if (tot_r == '0) begin
            out_prob_r <= p_rdata;
            state_r    <= S_OUT;
          end else begin
            div_ret_r <= S_NR_R;
            state_r   <= S_DIVW;
          end
        end
        S_NR_R: begin
          out_prob_r <= div_quo[31:0];
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (n_r == ord_r) begin
              state_r <= S_IDLE;
            end else begin
              n_r     <= n_r + 4'd1;
              state_r <= S_NR_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // shared divider
  cpp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // cluster weight store
  cpp_ram #(.WIDTH(32), .DEPTH(cpp_pkg::MAX_ORDER + 1)) u_gram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // term store
  cpp_ram #(.WIDTH(32), .DEPTH(cpp_pkg::MAX_ORDER + 1)) u_pram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // ports
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_count_index = n_r;
  assign out_probability = out_prob_r;
  assign out_last_term   = (n_r == ord_r);

  // checks
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVW) else $error("divider finished outside wait");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVW |-> !div_start) else $error("divider restarted while busy");
  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probability <= cpp_pkg::Q31_ONE) else $error("probability above one");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_term |=> in_ready) else $error("no idle after last");
endmodule
